FILE: rtl/assert_macros.svh
// assertion macros for the complex arithmetic unit
// used by the top level only
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked check, disabled while reset is asserted
`define CAU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication checked on every clock edge
`define CAU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`endif

FILE: rtl/cau_pkg.sv
// shared types and codes for the complex arithmetic unit
// no dependencies
package cau_pkg;

    // operation codes
    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_NEG = 3'd4
    } t_op;

    // control that travels with each item down the pipeline
    typedef struct packed {
        logic valid;
        logic is_div;
        logic div_zero;
        logic ov;
        logic neg_re;
        logic neg_im;
        logic big_re;
        logic big_im;
    } t_ctl;

endpackage

FILE: rtl/complex_arithmetic_unit.sv
// top level of the complex arithmetic unit: front stage, divider chain, output
// depends on cau_pkg, cau_mult_stage, cau_div_step, assert_macros.svh
//
// usage
//   an item (opcode, a_re, a_im, b_re, b_im) is taken at a rising edge with
//   i_start high and o_busy low; o_busy is always low, so an item may be
//   issued every cycle
//   each result is shown for one cycle with o_valid high and must be taken
//   then; the receiver cannot stall, and nothing in the pipe ever waits
//   every opcode passes the same registers: the product and sum stages,
//   the divide set-up register, one restoring divider step per quotient
//   bit and the output register; throughput is one item per cycle
//   add, subtract, multiply and negate ride along the divider chain so that
//   results leave in order
//   a zero divisor gives a zero result with o_div_zero set; saturation sets
//   o_overflowed
//   synchronous reset clears all valid bits; items in flight are dropped
module complex_arithmetic_unit import cau_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [2:0]                   i_opcode,
    input  logic signed [DATA_WIDTH-1:0] i_a_re,
    input  logic signed [DATA_WIDTH-1:0] i_a_im,
    input  logic signed [DATA_WIDTH-1:0] i_b_re,
    input  logic signed [DATA_WIDTH-1:0] i_b_im,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_res_re,
    output logic signed [DATA_WIDTH-1:0] o_res_im,
    output logic                         o_div_zero,
    output logic                         o_overflowed
);

`include "assert_macros.svh"

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int CW  = 3 * W + F;
    localparam int LAT = W + 4;
    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    assign o_busy = 1'b0;

    // front stage
    t_ctl             f_ctl;
    logic [W-1:0]     f_re, f_im;
    logic [2*W-1:0]   f_mag_re, f_mag_im, f_den;

    cau_mult_stage #(.W(W), .F(F)) u_mult (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_start),
        .i_op     (i_opcode),
        .i_a_re   (i_a_re),
        .i_a_im   (i_a_im),
        .i_b_re   (i_b_re),
        .i_b_im   (i_b_im),
        .o_ctl    (f_ctl),
        .o_re     (f_re),
        .o_im     (f_im),
        .o_mag_re (f_mag_re),
        .o_mag_im (f_mag_im),
        .o_den    (f_den)
    );

    // divider chain taps
    t_ctl           c_ctl    [0:W];
    logic [W-1:0]   c_re     [0:W];
    logic [W-1:0]   c_im     [0:W];
    logic [CW-1:0]  c_rem_re [0:W];
    logic [CW-1:0]  c_rem_im [0:W];
    logic [W-1:0]   c_q_re   [0:W];
    logic [W-1:0]   c_q_im   [0:W];
    logic [2*W-1:0] c_den    [0:W];

    // divide set-up: scaled dividend and whole-part range check
    logic [CW-1:0] n_re, n_im, d_top;
    t_ctl          n_ctl;

    assign n_re  = CW'(f_mag_re) << F;
    assign n_im  = CW'(f_mag_im) << F;
    assign d_top = CW'(f_den) << W;

    always_comb begin
        n_ctl        = f_ctl;
        n_ctl.big_re = (n_re >= d_top);
        n_ctl.big_im = (n_im >= d_top);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            c_ctl[0] <= '0;
        end else begin
            c_ctl[0] <= n_ctl;
        end
        c_re[0]     <= f_re;
        c_im[0]     <= f_im;
        c_rem_re[0] <= n_re;
        c_rem_im[0] <= n_im;
        c_q_re[0]   <= '0;
        c_q_im[0]   <= '0;
        c_den[0]    <= f_den;
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < W; k++) begin : g_div
        cau_div_step #(.W(W), .CW(CW), .SHIFT(W - 1 - k)) u_step (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (c_ctl[k]),
            .i_re     (c_re[k]),
            .i_im     (c_im[k]),
            .i_rem_re (c_rem_re[k]),
            .i_rem_im (c_rem_im[k]),
            .i_q_re   (c_q_re[k]),
            .i_q_im   (c_q_im[k]),
            .i_den    (c_den[k]),
            .o_ctl    (c_ctl[k+1]),
            .o_re     (c_re[k+1]),
            .o_im     (c_im[k+1]),
            .o_rem_re (c_rem_re[k+1]),
            .o_rem_im (c_rem_im[k+1]),
            .o_q_re   (c_q_re[k+1]),
            .o_q_im   (c_q_im[k+1]),
            .o_den    (c_den[k+1])
        );
    end

    // sign and saturation of the quotient parts, then result and flag select
    t_ctl         e_ctl;
    logic [W-1:0] q_re, q_im, v_re, v_im, n_res_re, n_res_im;
    logic         ov_re, ov_im, n_dz, n_ov;

    assign e_ctl = c_ctl[W];
    assign q_re  = c_q_re[W];
    assign q_im  = c_q_im[W];

    always_comb begin
        if (e_ctl.big_re) begin
            v_re  = e_ctl.neg_re ? VMIN : VMAX;
            ov_re = 1'b1;
        end else if (e_ctl.neg_re) begin
            ov_re = q_re[W-1] && (|q_re[W-2:0]);
            v_re  = ov_re ? VMIN : (~q_re + 1'b1);
        end else begin
            ov_re = q_re[W-1];
            v_re  = ov_re ? VMAX : q_re;
        end
        if (e_ctl.big_im) begin
            v_im  = e_ctl.neg_im ? VMIN : VMAX;
            ov_im = 1'b1;
        end else if (e_ctl.neg_im) begin
            ov_im = q_im[W-1] && (|q_im[W-2:0]);
            v_im  = ov_im ? VMIN : (~q_im + 1'b1);
        end else begin
            ov_im = q_im[W-1];
            v_im  = ov_im ? VMAX : q_im;
        end
        priority if (e_ctl.is_div && e_ctl.div_zero) begin
            n_res_re = '0;
            n_res_im = '0;
            n_dz     = 1'b1;
            n_ov     = 1'b0;
        end else if (e_ctl.is_div) begin
            n_res_re = v_re;
            n_res_im = v_im;
            n_dz     = 1'b0;
            n_ov     = ov_re | ov_im;
        end else begin
            n_res_re = c_re[W];
            n_res_im = c_im[W];
            n_dz     = 1'b0;
            n_ov     = e_ctl.ov;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= e_ctl.valid;
        end
        o_res_re     <= n_res_re;
        o_res_im     <= n_res_im;
        o_div_zero   <= n_dz;
        o_overflowed <= n_ov;
    end

    // checks
    `CAU_ASSERT_IMP(a_dz_clean, i_clk, i_rst_n, o_valid && o_div_zero,
        !o_overflowed && o_res_re == '0 && o_res_im == '0, "zero divisor result not clean")
    `CAU_ASSERT_IMP(a_latency, i_clk, i_rst_n, ##LAT 1'b1,
        o_valid == $past(i_start, LAT), "result strobe does not match issue")
    `CAU_ASSERT_IMP(a_dz_div_only, i_clk, i_rst_n, e_ctl.valid && e_ctl.div_zero,
        e_ctl.is_div, "zero divisor flag on a non-divide item")

endmodule

FILE: rtl/cau_mult_stage.sv
// front of the pipeline: products, sums, saturation of the direct results
// depends on cau_pkg
module cau_mult_stage import cau_pkg::*; #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [2:0]          i_op,
    input  logic signed [W-1:0] i_a_re,
    input  logic signed [W-1:0] i_a_im,
    input  logic signed [W-1:0] i_b_re,
    input  logic signed [W-1:0] i_b_im,
    output t_ctl                o_ctl,
    output logic [W-1:0]        o_re,
    output logic [W-1:0]        o_im,
    output logic [2*W-1:0]      o_mag_re,
    output logic [2*W-1:0]      o_mag_im,
    output logic [2*W-1:0]      o_den
);

    localparam int SW = 2 * W + 1;
    localparam logic signed [SW-1:0] VMAXE = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] VMINE = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

    // saturate to W bits, top bit of the result is the overflow flag
    function automatic logic [W:0] sat(input logic signed [SW-1:0] v);
        logic [W:0] r;
        if (v > VMAXE) begin
            r = {1'b1, VMAXE[W-1:0]};
        end else if (v < VMINE) begin
            r = {1'b1, VMINE[W-1:0]};
        end else begin
            r = {1'b0, v[W-1:0]};
        end
        return r;
    endfunction

    // stage one: products
    logic                  r_v1;
    logic [2:0]            r_op1;
    logic signed [W-1:0]   r_ar, r_ai, r_br, r_bi;
    logic signed [2*W-1:0] r_rr, r_ii, r_ir, r_ri, r_bb_r, r_bb_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_op1  <= i_op;
        r_ar   <= i_a_re;
        r_ai   <= i_a_im;
        r_br   <= i_b_re;
        r_bi   <= i_b_im;
        r_rr   <= i_a_re * i_b_re;
        r_ii   <= i_a_im * i_b_im;
        r_ir   <= i_a_im * i_b_re;
        r_ri   <= i_a_re * i_b_im;
        r_bb_r <= i_b_re * i_b_re;
        r_bb_i <= i_b_im * i_b_im;
    end

    // stage two: sums, shifts, saturation, divide operands
    logic signed [SW-1:0] m_re, m_im, d_re, d_im, x_ar, x_ai, x_br, x_bi;
    logic [SW-1:0]        mag_re, mag_im;
    logic [W:0]           s_re, s_im;
    logic [2*W-1:0]       den;
    t_ctl                 n_ctl;

    assign x_ar = SW'(r_ar);
    assign x_ai = SW'(r_ai);
    assign x_br = SW'(r_br);
    assign x_bi = SW'(r_bi);
    assign m_re = (SW'(r_rr) - SW'(r_ii)) >>> F;
    assign m_im = (SW'(r_ir) + SW'(r_ri)) >>> F;
    assign d_re = SW'(r_rr) + SW'(r_ii);
    assign d_im = SW'(r_ir) - SW'(r_ri);
    assign den  = r_bb_r + r_bb_i;

    // magnitudes of the divide numerators, always below 2^(2W)
    assign mag_re = d_re[SW-1] ? -d_re : d_re;
    assign mag_im = d_im[SW-1] ? -d_im : d_im;

    always_comb begin
        s_re = '0;
        s_im = '0;
        unique case (r_op1)
            OP_ADD: begin
                s_re = sat(x_ar + x_br);
                s_im = sat(x_ai + x_bi);
            end
            OP_SUB: begin
                s_re = sat(x_ar - x_br);
                s_im = sat(x_ai - x_bi);
            end
            OP_MUL: begin
                s_re = sat(m_re);
                s_im = sat(m_im);
            end
            OP_NEG: begin
                s_re = sat(-x_ar);
                s_im = sat(-x_ai);
            end
            default: begin
                s_re = '0;
                s_im = '0;
            end
        endcase
        n_ctl          = '0;
        n_ctl.valid    = r_v1;
        n_ctl.is_div   = (r_op1 == OP_DIV);
        n_ctl.div_zero = (r_op1 == OP_DIV) && (den == '0);
        n_ctl.ov       = s_re[W] | s_im[W];
        n_ctl.neg_re   = d_re[SW-1];
        n_ctl.neg_im   = d_im[SW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl <= n_ctl;
        end
        o_re     <= s_re[W-1:0];
        o_im     <= s_im[W-1:0];
        o_mag_re <= mag_re[2*W-1:0];
        o_mag_im <= mag_im[2*W-1:0];
        o_den    <= den;
    end

endmodule

FILE: rtl/cau_div_step.sv
// one restoring division step for both result parts, registered
// depends on cau_pkg
module cau_div_step import cau_pkg::*; #(
    parameter int W     = 32,
    parameter int CW    = 112,
    parameter int SHIFT = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_ctl            i_ctl,
    input  logic [W-1:0]    i_re,
    input  logic [W-1:0]    i_im,
    input  logic [CW-1:0]   i_rem_re,
    input  logic [CW-1:0]   i_rem_im,
    input  logic [W-1:0]    i_q_re,
    input  logic [W-1:0]    i_q_im,
    input  logic [2*W-1:0]  i_den,
    output t_ctl            o_ctl,
    output logic [W-1:0]    o_re,
    output logic [W-1:0]    o_im,
    output logic [CW-1:0]   o_rem_re,
    output logic [CW-1:0]   o_rem_im,
    output logic [W-1:0]    o_q_re,
    output logic [W-1:0]    o_q_im,
    output logic [2*W-1:0]  o_den
);

    logic [CW-1:0] d_sh;
    logic          ge_re, ge_im;

    // shifted divisor and trial compares
    assign d_sh  = CW'(i_den) << SHIFT;
    assign ge_re = (i_rem_re >= d_sh);
    assign ge_im = (i_rem_im >= d_sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl <= i_ctl;
        end
        o_re     <= i_re;
        o_im     <= i_im;
        o_den    <= i_den;
        o_rem_re <= ge_re ? i_rem_re - d_sh : i_rem_re;
        o_rem_im <= ge_im ? i_rem_im - d_sh : i_rem_im;
        o_q_re   <= {i_q_re[W-2:0], ge_re};
        o_q_im   <= {i_q_im[W-2:0], ge_im};
    end

endmodule
